### hw/rtl/rsi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_pkg
// shared widths, field offsets and the queue entry type of the ray-sphere block
// ----------------------------------------------------------------------------
package rsi_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int COORD_WIDTH = 32;
   localparam int CW          = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

   localparam int IN_W   = 32;
   localparam int DIR_W  = 18;
   localparam int RAD_W  = 31;
   localparam int M_W    = 33;
   localparam int PROD_W = 52;
   localparam int SQ2_W  = 66;
   localparam int RR_W   = 62;
   localparam int BSUM_W = 68;
   localparam int HD_W   = 53;
   localparam int LO_W   = 27;
   localparam int HI_W   = HD_W - LO_W;
   localparam int HD2_W  = 107;
   localparam int A_W    = 77;
   localparam int DET_W  = 76;
   localparam int SQ_W   = DET_W / 2;
   localparam int REM_W  = SQ_W + 3;
   localparam int T_W    = 40;
   localparam int PT_W   = DIR_W + T_W;
   localparam int SUM_W  = PT_W + 1;

   localparam int REQ_W = 280;
   localparam int RSP_W = 224;

   localparam int ORG_OFS = 0;
   localparam int DIR_OFS = 3 * IN_W;
   localparam int CEN_OFS = DIR_OFS + 3 * DIR_W;
   localparam int RAD_OFS = CEN_OFS + 3 * IN_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // one classified test waiting for the back end
   typedef struct packed {
      logic                      neg;
      logic [DET_W-1:0]          det;
      logic [HD_W-1:0]           h;
      logic [2:0][M_W-1:0]       org;
      logic [2:0][DIR_W-1:0]     dir;
   } job_type;

   function automatic logic [M_W-1:0] sext_cw(input logic [IN_W-1:0] x);
      logic signed [CW-1:0] v;
      v = $signed(x[CW-1:0]);
      return M_W'(v);
   endfunction

endpackage
`default_nettype wire

### hw/rtl/rsi_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_front
// accepts items, forms m, h, m.m, r^2 and the discriminant, classifies sign
// ----------------------------------------------------------------------------
module rsi_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [rsi_pkg::REQ_W-1:0]   req_tdata,
   output logic                        push,
   output rsi_pkg::job_type            push_job,
   input  logic                        q_full
);
   import rsi_pkg::*;

   logic [6:0] v_ff, v_in;
   logic       adv;

   logic [2:0][M_W-1:0]    org_in, mv_in, org0_ff, mv0_ff;
   logic [2:0][DIR_W-1:0]  dir_in, dir0_ff;
   logic [RAD_W-1:0]       rad_in, rad0_ff;

   logic [2:0][PROD_W-1:0] prod_in, prod1_ff;
   logic [2:0][SQ2_W-1:0]  sq_in, sq1_ff;
   logic [RR_W-1:0]        rr_in, rr1_ff, rr2_ff, rr3_ff, rr4_ff;
   logic [2:0][M_W-1:0]    org1_ff, org2_ff, org3_ff, org4_ff, org5_ff;
   logic [2:0][DIR_W-1:0]  dir1_ff, dir2_ff, dir3_ff, dir4_ff, dir5_ff;

   logic [HD_W-1:0]        hd_in, hd2_ff, hd3_ff, hd4_ff, hd5_ff;
   logic [BSUM_W-1:0]      bsum_in, bsum2_ff, bsum3_ff, bsum4_ff, bsum5_ff;
   logic [HD_W-1:0]        absd_in, absd3_ff;
   logic [2*LO_W-1:0]      pll_in, pll4_ff;
   logic [LO_W+HI_W-1:0]   plh_in, plh4_ff;
   logic [2*HI_W-1:0]      phh_in, phh4_ff;
   logic [HD2_W-1:0]       hdsq;
   logic [A_W-1:0]         a_in, a5_ff;
   logic [A_W:0]           diff;
   logic signed [HD_W-1:0] h_sh;
   job_type                job_in, job6_ff;

   assign adv        = !(v_ff[6] && q_full);
   assign req_tready = adv;
   assign push       = v_ff[6] && !q_full;
   assign push_job   = job6_ff;
   assign v_in       = {v_ff[5:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // unpack and take m = origin - center
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         org_in[i] = sext_cw(req_tdata[ORG_OFS + i*IN_W +: IN_W]);
         dir_in[i] = req_tdata[DIR_OFS + i*DIR_W +: DIR_W];
         mv_in[i]  = org_in[i] - sext_cw(req_tdata[CEN_OFS + i*IN_W +: IN_W]);
      end
      rad_in = req_tdata[RAD_OFS +: RAD_W];
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = $signed(mv0_ff[i]) * $signed(dir0_ff[i]);
         sq_in[i]   = $signed(mv0_ff[i]) * $signed(mv0_ff[i]);
      end
      rr_in = rad0_ff * rad0_ff;
   end

   always_comb begin
      hd_in   = $signed(prod1_ff[0]) + $signed(prod1_ff[1]) + $signed(prod1_ff[2]);
      bsum_in = BSUM_W'(sq1_ff[0]) + BSUM_W'(sq1_ff[1]) + BSUM_W'(sq1_ff[2]);
      absd_in = hd2_ff[HD_W-1] ? (-hd2_ff) : hd2_ff;
      pll_in  = absd3_ff[LO_W-1:0] * absd3_ff[LO_W-1:0];
      plh_in  = absd3_ff[LO_W-1:0] * absd3_ff[HD_W-1:LO_W];
      phh_in  = absd3_ff[HD_W-1:LO_W] * absd3_ff[HD_W-1:LO_W];
      hdsq    = (HD2_W'(phh4_ff) << (2*LO_W)) + (HD2_W'(plh4_ff) << (LO_W+1))
                + HD2_W'(pll4_ff);
      a_in    = A_W'(hdsq >> (2*FRAC_BITS)) + A_W'(rr4_ff);
      diff    = (A_W+1)'(a5_ff) - (A_W+1)'(bsum5_ff);
      h_sh    = $signed(hd5_ff) >>> FRAC_BITS;
      job_in.neg = diff[A_W];
      job_in.det = diff[DET_W-1:0];
      job_in.h   = h_sh;
      job_in.org = org5_ff;
      job_in.dir = dir5_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         org0_ff  <= org_in;   mv0_ff   <= mv_in;    dir0_ff <= dir_in;  rad0_ff <= rad_in;
         prod1_ff <= prod_in;  sq1_ff   <= sq_in;    rr1_ff  <= rr_in;
         org1_ff  <= org0_ff;  dir1_ff  <= dir0_ff;
         hd2_ff   <= hd_in;    bsum2_ff <= bsum_in;  rr2_ff  <= rr1_ff;
         org2_ff  <= org1_ff;  dir2_ff  <= dir1_ff;
         absd3_ff <= absd_in;  hd3_ff   <= hd2_ff;   bsum3_ff <= bsum2_ff;
         rr3_ff   <= rr2_ff;   org3_ff  <= org2_ff;  dir3_ff <= dir2_ff;
         pll4_ff  <= pll_in;   plh4_ff  <= plh_in;   phh4_ff <= phh_in;
         hd4_ff   <= hd3_ff;   bsum4_ff <= bsum3_ff; rr4_ff  <= rr3_ff;
         org4_ff  <= org3_ff;  dir4_ff  <= dir3_ff;
         a5_ff    <= a_in;     hd5_ff   <= hd4_ff;   bsum5_ff <= bsum4_ff;
         org5_ff  <= org4_ff;  dir5_ff  <= dir4_ff;
         job6_ff  <= job_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/rsi_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_queue
// short first-in first-out queue between the front and back ends
// ----------------------------------------------------------------------------
module rsi_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rsi_pkg::job_type push_job,
   output logic             q_full,
   input  logic             pop,
   output logic             q_valid,
   output rsi_pkg::job_type q_job
);
   import rsi_pkg::*;

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;

   assign q_full  = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_valid = (cnt_ff != '0);
   assign q_job   = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/rsi_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_back
// bit-per-stage square root, roots, intersection points and result register
// ----------------------------------------------------------------------------
module rsi_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  rsi_pkg::job_type            q_job,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [rsi_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                        rsp_tuser
);
   import rsi_pkg::*;

   localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (CW-1)) - 64'sd1;
   localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
   localparam logic [63:0]        UMAX   = (64'd1 << CW) - 64'd1;

   logic adv;

   logic             sv_ff   [SQ_W];
   logic [REM_W-1:0] rem_ff  [SQ_W];
   logic [SQ_W-1:0]  root_ff [SQ_W];
   job_type          sj_ff   [SQ_W];
   logic [REM_W-1:0] rem_in  [SQ_W];
   logic [SQ_W-1:0]  root_in [SQ_W];

   logic                    tv_ff, pv_ff, rsp_tvalid_ff;
   logic signed [T_W-1:0]   t1_in, t2_in, t1_ff, t2_ff, t1p_ff, t2p_ff;
   logic                    hit_in, hit_ff, hitp_ff;
   logic [2:0][M_W-1:0]     orgt_ff, orgp_ff;
   logic [2:0][DIR_W-1:0]   dirt_ff;
   logic [2:0][PT_W-1:0]    pn_in, pf_in, pn_ff, pf_ff;
   logic signed [HD_W+1:0]  sw, hw;
   logic [RSP_W-1:0]        rsp_tdata_in, rsp_tdata_ff;
   logic                    rsp_tuser_ff;
   logic signed [T_W-1:0]   tn;

   function automatic logic [IN_W-1:0] place(input logic [M_W-1:0] org,
                                             input logic [PT_W-1:0] prod);
      logic signed [SUM_W-1:0] sum;
      logic signed [PT_W-1:0]  shp;
      logic signed [63:0]      wide;
      logic signed [CW-1:0]    nar;
      shp  = $signed(prod) >>> FRAC_BITS;
      sum  = SUM_W'($signed(org)) + SUM_W'(shp);
      wide = 64'(sum);
      if (wide > SAT_HI) begin
         wide = SAT_HI;
      end else if (wide < SAT_LO) begin
         wide = SAT_LO;
      end
      nar = wide[CW-1:0];
      return IN_W'(nar);
   endfunction

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign pop        = adv && q_valid;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // one root bit per stage, two radicand bits consumed per stage
   always_comb begin
      for (int i = 0; i < SQ_W; i++) begin
         logic [REM_W-1:0] prem, rsh, trial;
         logic [SQ_W-1:0]  proot;
         logic [1:0]       dig;
         if (i == 0) begin
            prem  = '0;
            proot = '0;
            dig   = q_job.det[2*(SQ_W-1) +: 2];
         end else begin
            prem  = rem_ff[i-1];
            proot = root_ff[i-1];
            dig   = sj_ff[i-1].det[2*(SQ_W-1-i) +: 2];
         end
         rsh   = {prem[REM_W-3:0], dig};
         trial = REM_W'({proot, 2'b01});
         if (rsh >= trial) begin
            rem_in[i]  = rsh - trial;
            root_in[i] = {proot[SQ_W-2:0], 1'b1};
         end else begin
            rem_in[i]  = rsh;
            root_in[i] = {proot[SQ_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SQ_W; i++) begin
            sv_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         sv_ff[0] <= q_valid;
         for (int i = 1; i < SQ_W; i++) begin
            sv_ff[i] <= sv_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= rem_in[0];
         root_ff[0] <= root_in[0];
         sj_ff[0]   <= q_job;
         for (int i = 1; i < SQ_W; i++) begin
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            sj_ff[i]   <= sj_ff[i-1];
         end
      end
   end

   // roots t1 = s - h and t2 = -s - h
   always_comb begin
      sw     = $signed((HD_W+2)'(root_ff[SQ_W-1]));
      hw     = (HD_W+2)'($signed(sj_ff[SQ_W-1].h));
      t1_in  = T_W'(sw - hw);
      t2_in  = T_W'(-sw - hw);
      hit_in = !sj_ff[SQ_W-1].neg && !t1_in[T_W-1];
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pn_in[i] = $signed(dirt_ff[i]) * t1_ff;
         pf_in[i] = $signed(dirt_ff[i]) * t2_ff;
      end
   end

   always_comb begin
      rsp_tdata_in = '0;
      tn = t2p_ff[T_W-1] ? t1p_ff : t2p_ff;
      if (hitp_ff) begin
         for (int i = 0; i < 3; i++) begin
            rsp_tdata_in[i*IN_W +: IN_W]     = place(orgp_ff[i], pn_ff[i]);
            rsp_tdata_in[(3+i)*IN_W +: IN_W] = place(orgp_ff[i], pf_ff[i]);
         end
         if (64'(tn) > UMAX) begin
            rsp_tdata_in[6*IN_W +: IN_W] = IN_W'(UMAX);
         end else begin
            rsp_tdata_in[6*IN_W +: IN_W] = IN_W'(tn);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff         <= 1'b0;
         pv_ff         <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         tv_ff         <= sv_ff[SQ_W-1];
         pv_ff         <= tv_ff;
         rsp_tvalid_ff <= pv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff        <= t1_in;
         t2_ff        <= t2_in;
         hit_ff       <= hit_in;
         orgt_ff      <= sj_ff[SQ_W-1].org;
         dirt_ff      <= sj_ff[SQ_W-1].dir;
         pn_ff        <= pn_in;
         pf_ff        <= pf_in;
         t1p_ff       <= t1_ff;
         t2p_ff       <= t2_ff;
         hitp_ff      <= hit_ff;
         orgp_ff      <= orgt_ff;
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= hitp_ff;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/ray_sphere_intersect.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// streaming ray against sphere test in signed fixed point
// ----------------------------------------------------------------------------
// one test per item, one result item per test, full rate: a new item can be
// taken every cycle while req_tready is high. the front end forms m, the dot
// products, the squared dot product split into partial products and the
// discriminant; the item then passes through the queue, the square root (one
// root bit per stage, the first bit taken as the item leaves the queue) and
// registers for roots, points and the result. a 4-item queue lets the front
// keep accepting while the result side is stalled; once it is full and the
// front's last stage holds an item, req_tready drops. when the discriminant
// is negative or both roots are negative, hit is 0 and every other field
// is 0. points saturate to signed 32 bits, distance to unsigned.
module ray_sphere_intersect (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, center_x, center_y,
   // center_z, sphere_radius, zero pad to 280 bits
   input  logic [rsi_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // far_x, far_y, far_z, near_x, near_y, near_z, nearest_distance
   output logic [rsi_pkg::RSP_W-1:0]   rsp_tdata,
   // hit
   output logic                        rsp_tuser
);
   import rsi_pkg::*;

   logic    push, q_full, pop, q_valid;
   job_type push_job, q_job;

   // front: accept and classify
   rsi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_job   (push_job),
      .q_full     (q_full)
   );

   // decoupling queue
   rsi_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .q_full   (q_full),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_job    (q_job)
   );

   // back: root, points, result register
   rsi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_job      (q_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire
